// ===== src/atf_pkg.sv =====
// ----------------------------------------------------------------------------
// atf_pkg
// Shared types and constants of the alphabet threshold finder: request and
// status codes, register indexes, controller states and the control word of
// the histogram store.
// ----------------------------------------------------------------------------
package atf_pkg;

  typedef enum logic [1:0] {
    REQ_COUNT         = 2'd0,
    REQ_FINISH        = 2'd1,
    REQ_READ_ALPHA    = 2'd2,
    REQ_READ_COLLAPSE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_CHARS    = 2'd1,
    STATUS_EMPTY_ALPHA = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_SCAN,
    ST_TAIL,
    ST_FIN,
    ST_READ
  } state_t;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FOLD_CASE = 2'd1;
  localparam logic [1:0] REG_MERGE     = 2'd2;

  localparam int THR_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int PROD_W  = 48;
  localparam int LEN_W   = 9;
  localparam int CODE_W  = 8;

  localparam logic [CODE_W-1:0] CODE_UNIT_SEP = 8'd31;
  localparam logic [CODE_W-1:0] CODE_SPACE    = 8'd32;
  localparam logic [CODE_W-1:0] CODE_TAB      = 8'd9;
  localparam logic [CODE_W-1:0] CODE_CR       = 8'd13;
  localparam logic [CODE_W-1:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [CODE_W-1:0] CASE_OFFSET   = 8'd32;
  localparam logic [PROD_W-1:0] ROUND_HALF    = 48'h8000;

  typedef struct packed {
    logic inc;      // read now, increment and write back next cycle
    logic scan_rd;  // plain read for the finish scan
    logic clear;    // drop every entry back to zero
  } hist_ctl_t;

endpackage

// ===== src/alphabet_threshold_finder.sv =====
// ----------------------------------------------------------------------------
// alphabet_threshold_finder
// Character histogram with a threshold-based alphabet and collapse list.
// ----------------------------------------------------------------------------
// Count words are taken one per cycle while the block is idle: each is a read
// of the histogram RAM and a write-back of the incremented count in the next
// cycle, overlapped with the following word. A finish word runs a scan that
// reads every histogram entry once through the single RAM port: the accepting
// cycle, the threshold multiply, the entry reads, a drain of the last read and
// the closing of the lists, before its result is offered; it also clears the
// histogram at once through per-entry valid bits. A read word goes through
// the registered list RAMs.
// Count words are accepted while a result waits on the output; finish and
// read words hold their result until the output register is free.
// ----------------------------------------------------------------------------
module alphabet_threshold_finder #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol [7:0], entry_index [15:8]
  input  logic [1:0]  s_axis_tuser,  // req_type [1:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], alphabet_len [10:2], collapse_len [19:11],
  // min_cnt_out [51:20], entry_code [59:52], entry_valid [60], zero [63:61]
  output logic [63:0] m_axis_tdata
);

  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int LEN_W = atf_pkg::LEN_W;
  localparam logic [SYM_W-1:0] LAST_ADDR = SYM_W'(SYMBOLS - 1);

  // Configuration registers
  logic [atf_pkg::THR_W-1:0] threshold_q16;
  logic                      fold_case;
  logic                      merge_spaces;
  logic                      cfg_wr;

  atf_pkg::state_t state, state_next;

  logic [atf_pkg::TOTAL_W-1:0] total_count;
  logic [atf_pkg::CODE_W-1:0]  last_counted;
  logic [LEN_W-1:0]            alphabet_count;
  logic [LEN_W-1:0]            collapse_count;
  logic                        rep_have;
  logic [atf_pkg::CODE_W-1:0]  rep_code;

  // Input word
  atf_pkg::req_t              req;
  logic [atf_pkg::CODE_W-1:0] symbol;
  logic [atf_pkg::CODE_W-1:0] entry_index;
  logic                       accept;
  logic [atf_pkg::CODE_W-1:0] mapped;
  logic                       count_take;
  logic                       count_go;

  // Finish scan
  logic [atf_pkg::PROD_W-1:0]  prod;
  logic [atf_pkg::TOTAL_W-1:0] alpha_floor;
  logic [SYM_W-1:0]            scan_addr;
  logic                        proc_vld;
  logic [SYM_W-1:0]            proc_addr;
  logic [atf_pkg::TOTAL_W-1:0] proc_cnt;
  logic [LEN_W-1:0]            freq_n;
  logic [LEN_W-1:0]            rare_n;

  atf_pkg::hist_ctl_t    hist_ctl;
  logic [SYM_W-1:0]      hist_addr;
  logic [COUNT_BITS-1:0] hist_count;

  // List RAMs
  logic [atf_pkg::CODE_W-1:0] alpha_mem [SYMBOLS];
  logic [atf_pkg::CODE_W-1:0] col_mem   [SYMBOLS];
  logic [atf_pkg::CODE_W-1:0] alpha_q;
  logic [atf_pkg::CODE_W-1:0] col_q;
  logic [atf_pkg::CODE_W-1:0] alpha_rd_idx;
  logic                       rd_alpha;
  logic                       rd_hit;
  logic                       rd_use_rep;
  logic                       rd_go;
  logic                       rd_hit_next;

  // Finish outcome
  logic              fin_have_rep;
  logic [LEN_W-1:0]  fin_a;
  logic [LEN_W-1:0]  fin_k;
  atf_pkg::status_t  fin_status;

  // Output
  logic        out_free;
  logic        out_load;
  logic        fin_load;
  logic [63:0] res_data;
  logic [atf_pkg::CODE_W-1:0] rd_code;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_q16 <= '0;
      fold_case     <= 1'b0;
      merge_spaces  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        atf_pkg::REG_THRESHOLD: threshold_q16 <= pwdata[atf_pkg::THR_W-1:0];
        atf_pkg::REG_FOLD_CASE: fold_case     <= pwdata[0];
        atf_pkg::REG_MERGE:     merge_spaces  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      atf_pkg::REG_THRESHOLD: prdata = 32'(threshold_q16);
      atf_pkg::REG_FOLD_CASE: prdata = 32'(fold_case);
      atf_pkg::REG_MERGE:     prdata = 32'(merge_spaces);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign req         = atf_pkg::req_t'(s_axis_tuser);
  assign symbol      = s_axis_tdata[7:0];
  assign entry_index = s_axis_tdata[15:8];
  assign accept      = s_axis_tvalid & s_axis_tready;

  always_comb begin
    mapped     = symbol;
    count_take = (symbol != '0);
    if (mapped == atf_pkg::CODE_UNIT_SEP) begin
      mapped = atf_pkg::CODE_SPACE;
    end
    if (merge_spaces && ((mapped == atf_pkg::CODE_SPACE) ||
        ((mapped >= atf_pkg::CODE_TAB) && (mapped <= atf_pkg::CODE_CR)))) begin
      mapped = atf_pkg::CODE_SPACE;
      if (last_counted == atf_pkg::CODE_SPACE) begin
        count_take = 1'b0;
      end
    end
    if (fold_case && (mapped >= atf_pkg::CHAR_UPPER_A) &&
        (mapped <= atf_pkg::CHAR_UPPER_Z)) begin
      mapped = mapped + atf_pkg::CASE_OFFSET;
    end
    if ({1'b0, mapped} >= 9'(SYMBOLS)) begin
      count_take = 1'b0;
    end
  end

  assign count_go = accept && (req == atf_pkg::REQ_COUNT) && count_take;
  assign rd_go    = accept && ((req == atf_pkg::REQ_READ_ALPHA) ||
                               (req == atf_pkg::REQ_READ_COLLAPSE));

  // ---------------------------------------------------------------- histogram
  atf_hist #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hist_ctl),
    .addr     (hist_addr),
    .rd_count (hist_count)
  );

  // ---------------------------------------------------------------- control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == atf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    hist_ctl      = '0;
    hist_addr     = mapped[SYM_W-1:0];
    out_load      = 1'b0;
    fin_load      = 1'b0;
    case (state)
      atf_pkg::ST_IDLE: begin
        hist_ctl.inc  = count_go;
        if (accept) begin
          case (req)
            atf_pkg::REQ_FINISH:        state_next = atf_pkg::ST_MULT;
            atf_pkg::REQ_READ_ALPHA:    state_next = atf_pkg::ST_READ;
            atf_pkg::REQ_READ_COLLAPSE: state_next = atf_pkg::ST_READ;
            default:                    state_next = atf_pkg::ST_IDLE;
          endcase
        end
      end
      atf_pkg::ST_MULT: begin
        state_next = atf_pkg::ST_SCAN;
      end
      atf_pkg::ST_SCAN: begin
        hist_ctl.scan_rd = 1'b1;
        hist_addr        = scan_addr;
        if (scan_addr == LAST_ADDR) begin
          state_next = atf_pkg::ST_TAIL;
        end
      end
      atf_pkg::ST_TAIL: begin
        state_next = atf_pkg::ST_FIN;
      end
      atf_pkg::ST_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          fin_load       = 1'b1;
          hist_ctl.clear = 1'b1;
          state_next     = atf_pkg::ST_IDLE;
        end
      end
      atf_pkg::ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = atf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = atf_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- counting
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count  <= '0;
      last_counted <= '0;
    end else if (fin_load) begin
      total_count  <= '0;
      last_counted <= '0;
    end else if (count_go) begin
      if (total_count != '1) begin
        total_count <= total_count + 1'b1;
      end
      last_counted <= mapped;
    end
  end

  // ---------------------------------------------------------------- finish scan
  always_ff @(posedge clk) begin
    if (state == atf_pkg::ST_MULT) begin
      prod <= atf_pkg::PROD_W'(threshold_q16) * atf_pkg::PROD_W'(total_count)
              + atf_pkg::ROUND_HALF;
    end
  end

  assign alpha_floor = (prod[47:16] == '0) ? 32'd1 : prod[47:16];
  assign proc_cnt    = 32'(hist_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= hist_ctl.scan_rd;
    end
  end

  // Rare codes all go to the collapse RAM in ascending order; the last one
  // becomes the first alphabet entry and is dropped from the collapse length.
  always_ff @(posedge clk) begin
    if (state == atf_pkg::ST_MULT) begin
      scan_addr <= '0;
      freq_n    <= '0;
      rare_n    <= '0;
    end else begin
      if (hist_ctl.scan_rd) begin
        scan_addr <= scan_addr + 1'b1;
        proc_addr <= scan_addr;
      end
      if (proc_vld) begin
        if (proc_cnt >= alpha_floor) begin
          alpha_mem[freq_n[SYM_W-1:0]] <= atf_pkg::CODE_W'(proc_addr);
          freq_n                       <= freq_n + 1'b1;
        end else if (proc_cnt != '0) begin
          col_mem[rare_n[SYM_W-1:0]] <= atf_pkg::CODE_W'(proc_addr);
          rare_n                     <= rare_n + 1'b1;
          rep_code                   <= atf_pkg::CODE_W'(proc_addr);
        end
      end
    end
  end

  always_comb begin
    fin_have_rep = (rare_n != '0);
    fin_a        = freq_n + LEN_W'(fin_have_rep);
    fin_k        = rare_n - LEN_W'(fin_have_rep);
    if (total_count == '0) begin
      fin_status = atf_pkg::STATUS_NO_CHARS;
    end else if (fin_a == '0) begin
      fin_status = atf_pkg::STATUS_EMPTY_ALPHA;
    end else begin
      fin_status = atf_pkg::STATUS_OK;
    end
    if (fin_status != atf_pkg::STATUS_OK) begin
      fin_a = '0;
      fin_k = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_count <= '0;
      collapse_count <= '0;
      rep_have       <= 1'b0;
    end else if (fin_load) begin
      alphabet_count <= fin_a;
      collapse_count <= fin_k;
      rep_have       <= fin_have_rep;
    end
  end

  // ---------------------------------------------------------------- list reads
  // With a representative in front, alphabet entry i lies at RAM word i - 1.
  assign alpha_rd_idx = entry_index - atf_pkg::CODE_W'(rep_have);

  always_comb begin
    if (req == atf_pkg::REQ_READ_ALPHA) begin
      rd_hit_next = ({1'b0, entry_index} < alphabet_count);
    end else begin
      rd_hit_next = ({1'b0, entry_index} < collapse_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      alpha_q    <= alpha_mem[alpha_rd_idx[SYM_W-1:0]];
      col_q      <= col_mem[entry_index[SYM_W-1:0]];
      rd_alpha   <= (req == atf_pkg::REQ_READ_ALPHA);
      rd_hit     <= rd_hit_next;
      rd_use_rep <= rep_have && (entry_index == '0);
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    if (!rd_hit) begin
      rd_code = '0;
    end else if (!rd_alpha) begin
      rd_code = col_q;
    end else if (rd_use_rep) begin
      rd_code = rep_code;
    end else begin
      rd_code = alpha_q;
    end
    if (state == atf_pkg::ST_FIN) begin
      res_data = {3'b000, 1'b0, 8'h00, alpha_floor, fin_k, fin_a, fin_status};
    end else begin
      res_data = {3'b000, rd_hit, rd_code, 32'h0000_0000, collapse_count,
                  alphabet_count, atf_pkg::STATUS_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_data;
    end
  end

`ifndef SYNTHESIS
  // A histogram write-back never overlaps the finish scan.
  a_wb_not_in_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && (req == atf_pkg::REQ_COUNT)) |=>
      ((state == atf_pkg::ST_IDLE) || (state == atf_pkg::ST_MULT)))
    else $error("histogram write-back overlaps the scan");

  // The two lists together never hold more codes than exist.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, alphabet_count} + {1'b0, collapse_count} <= 10'(SYMBOLS)))
    else $error("list lengths exceed the code space");

  // An error result always reports empty lists.
  a_err_lengths: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[1:0] != atf_pkg::STATUS_OK)) |->
      (m_axis_tdata[19:2] == '0))
    else $error("error result with non-zero lengths");
`endif

endmodule

// ===== src/atf_hist.sv =====
// ----------------------------------------------------------------------------
// atf_hist
// Histogram store: a synchronous RAM with one valid bit per entry, so that a
// whole clear is a single reset of the valid bits. Increments are
// read-modify-write: a read, then a write-back of the incremented count, with
// the previous write forwarded when back-to-back increments hit the same entry.
// ----------------------------------------------------------------------------
module atf_hist #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  atf_pkg::hist_ctl_t         ctl,
  input  logic [$clog2(SYMBOLS)-1:0] addr,
  output logic [COUNT_BITS-1:0]      rd_count
);

  localparam int SYM_W = $clog2(SYMBOLS);

  logic [COUNT_BITS-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0]    hvalid;
  logic [COUNT_BITS-1:0] q;
  logic                  q_vld;
  logic                  wb_en;
  logic [SYM_W-1:0]      wb_addr;
  logic [COUNT_BITS-1:0] wb_data;
  logic                  fwd_en;
  logic [SYM_W-1:0]      fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] base;
  logic                  rd_en;

  assign rd_en = ctl.inc | ctl.scan_rd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q     <= mem[addr];
      q_vld <= hvalid[addr];
    end
    if (wb_en) begin
      mem[wb_addr] <= wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      wb_en  <= 1'b0;
      fwd_en <= 1'b0;
    end else begin
      wb_en  <= ctl.inc;
      fwd_en <= wb_en;
      if (ctl.clear) begin
        hvalid <= '0;
      end else if (wb_en) begin
        hvalid[wb_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.inc) begin
      wb_addr <= addr;
    end
    if (wb_en) begin
      fwd_addr <= wb_addr;
      fwd_data <= wb_data;
    end
  end

  // The read of this increment happened at the edge of the previous write,
  // so the RAM returned the old word; take the written one instead.
  always_comb begin
    if (fwd_en && (fwd_addr == wb_addr)) begin
      base = fwd_data;
    end else if (q_vld) begin
      base = q;
    end else begin
      base = '0;
    end
    wb_data = (&base) ? base : base + 1'b1;
  end

  assign rd_count = q_vld ? q : '0;

endmodule

// ===== tb/alphabet_threshold_finder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alphabet_threshold_finder_tb
// Self-checking testbench for the alphabet threshold finder. Character, finish
// and list read words are streamed in with random bursts and gaps while the
// result side stalls on its own pattern. A model of the histogram and of the
// list building predicts every finish and read result, which is then checked
// field by field against the output stream. Configuration is changed over the
// register port between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module alphabet_threshold_finder_tb;

  localparam int SYMBOLS      = 256;
  localparam int DRAIN_CYCLES = SYMBOLS + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RX_FLOW      = 0;
  localparam int RX_STALL     = 1;
  localparam int RX_CHOPPY    = 2;

  typedef struct packed {
    atf_pkg::status_t           status;
    logic [atf_pkg::LEN_W-1:0]  alpha_len;
    logic [atf_pkg::LEN_W-1:0]  coll_len;
    logic [31:0]                floor_cnt;
    logic [atf_pkg::CODE_W-1:0] code;
    logic                       valid;
  } atf_result_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // symbol [7:0], entry_index [15:8]
  logic [1:0]  s_axis_tuser  = '0;  // req_type [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status [1:0], alphabet_len [10:2], collapse_len [19:11],
  // min_cnt_out [51:20], entry_code [59:52], entry_valid [60]
  logic [63:0] m_axis_tdata;

  // Predicted block state and configuration.
  logic [31:0]               hist_count [SYMBOLS];
  logic [31:0]               char_total     = '0;
  logic [7:0]                prev_char      = '0;
  logic [7:0]                alpha_codes    [SYMBOLS];
  logic [7:0]                collapse_codes [SYMBOLS];
  logic [atf_pkg::LEN_W-1:0] alpha_len_q    = '0;
  logic [atf_pkg::LEN_W-1:0] coll_len_q     = '0;
  logic [15:0]               cfg_threshold  = '0;
  bit                        cfg_fold       = 1'b0;
  bit                        cfg_merge      = 1'b0;

  atf_result_t expected_results [$];
  int          mismatches  = 0;
  int          words_sent  = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  int          rx_left     = 0;
  int          rx_mode     = RX_FLOW;

  alphabet_threshold_finder #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (32)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SYMBOLS; i++) begin
      hist_count[i] = '0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver alternates between flowing freely, stalling outright and
  // accepting on a coin toss.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_FLOW, RX_CHOPPY);
      rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 12) : $urandom_range(4, 40);
    end
    rx_left--;
    m_axis_tready <= (rx_mode == RX_FLOW) ||
                     (rx_mode == RX_CHOPPY && $urandom_range(0, 1) == 1);
  end

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
    end
  endfunction

  // Updates the predicted state for one accepted word; returns 1 and the
  // expected result when the word produces one.
  function automatic bit histogram_step(atf_pkg::req_t req, logic [7:0] sym,
                                        logic [7:0] idx, output atf_result_t r);
    logic [7:0]                c;
    logic [63:0]               prod;
    logic [31:0]               min_cnt;
    logic [atf_pkg::LEN_W-1:0] a;
    logic [atf_pkg::LEN_W-1:0] k;
    logic [7:0]                rep;
    bit                        have_rep;
    r = '0;
    case (req)
      atf_pkg::REQ_COUNT: begin
        if (sym == 8'd0) return 1'b0;
        c = (sym == atf_pkg::CODE_UNIT_SEP) ? atf_pkg::CODE_SPACE : sym;
        if (cfg_merge && (c == atf_pkg::CODE_SPACE ||
            (c >= atf_pkg::CODE_TAB && c <= atf_pkg::CODE_CR))) begin
          c = atf_pkg::CODE_SPACE;
          // A space straight after a counted space is dropped.
          if (c == prev_char) return 1'b0;
        end
        if (cfg_fold && c >= atf_pkg::CHAR_UPPER_A && c <= atf_pkg::CHAR_UPPER_Z) begin
          c = c + atf_pkg::CASE_OFFSET;
        end
        if (hist_count[c] != '1) hist_count[c]++;
        if (char_total != '1) char_total++;
        prev_char = c;
        return 1'b0;
      end
      atf_pkg::REQ_FINISH: begin
        prod    = 64'(cfg_threshold) * 64'(char_total) + 64'h8000;
        min_cnt = prod[47:16];
        if (min_cnt == 0) min_cnt = 1;
        a        = '0;
        k        = '0;
        rep      = '0;
        have_rep = 1'b0;
        r.status = atf_pkg::STATUS_OK;
        if (char_total == 0) begin
          r.status = atf_pkg::STATUS_NO_CHARS;
        end else begin
          // The highest-coded rare character leads the alphabet.
          for (int i = 0; i < SYMBOLS; i++) begin
            if (hist_count[i] != 0 && hist_count[i] < min_cnt) begin
              rep      = 8'(i);
              have_rep = 1'b1;
            end
          end
          if (have_rep) begin
            alpha_codes[0] = rep;
            a = 1;
          end
          for (int i = 0; i < SYMBOLS; i++) begin
            if (hist_count[i] >= min_cnt) begin
              alpha_codes[a[7:0]] = 8'(i);
              a++;
            end else if (hist_count[i] != 0 && !(have_rep && i == rep)) begin
              collapse_codes[k[7:0]] = 8'(i);
              k++;
            end
          end
          if (a == 0) r.status = atf_pkg::STATUS_EMPTY_ALPHA;
        end
        if (r.status != atf_pkg::STATUS_OK) begin
          a = '0;
          k = '0;
        end
        alpha_len_q = a;
        coll_len_q  = k;
        for (int i = 0; i < SYMBOLS; i++) begin
          hist_count[i] = '0;
        end
        char_total  = '0;
        prev_char   = '0;
        r.alpha_len = a;
        r.coll_len  = k;
        r.floor_cnt = min_cnt;
        return 1'b1;
      end
      default: begin
        r.status    = atf_pkg::STATUS_OK;
        r.alpha_len = alpha_len_q;
        r.coll_len  = coll_len_q;
        if (req == atf_pkg::REQ_READ_ALPHA) begin
          if (idx < alpha_len_q) begin
            r.code  = alpha_codes[idx];
            r.valid = 1'b1;
          end
        end else if (idx < coll_len_q) begin
          r.code  = collapse_codes[idx];
          r.valid = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    atf_result_t got;
    atf_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status    = atf_pkg::status_t'(m_axis_tdata[1:0]);
      got.alpha_len = m_axis_tdata[10:2];
      got.coll_len  = m_axis_tdata[19:11];
      got.floor_cnt = m_axis_tdata[51:20];
      got.code      = m_axis_tdata[59:52];
      got.valid     = m_axis_tdata[60];
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result word with nothing expected: %h", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.alpha_len !== want.alpha_len ||
            got.coll_len !== want.coll_len || got.floor_cnt !== want.floor_cnt ||
            got.code !== want.code || got.valid !== want.valid) begin
          note_mismatch($sformatf({"expected status %0d alen %0d clen %0d min %0d code %0d ",
                                   "valid %0d, got status %0d alen %0d clen %0d min %0d ",
                                   "code %0d valid %0d"},
                                  want.status, want.alpha_len, want.coll_len,
                                  want.floor_cnt, want.code, want.valid,
                                  got.status, got.alpha_len, got.coll_len,
                                  got.floor_cnt, got.code, got.valid));
        end
      end
    end
  end

  task automatic send_word(atf_pkg::req_t req, logic [7:0] sym, logic [7:0] idx);
    int          gap;
    atf_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, sym};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    if (req != atf_pkg::REQ_COUNT || sym != 8'd0) words_sent++;
    if (histogram_step(req, sym, idx, want)) expected_results.push_back(want);
  endtask

  // Waits for every result, then long enough for a trailing count word or a
  // finish scan to complete inside the block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] thr, bit fold, bit merge);
    logic [31:0] value [3];
    logic [1:0]  regs  [3];
    regs[0]  = atf_pkg::REG_THRESHOLD;
    regs[1]  = atf_pkg::REG_FOLD_CASE;
    regs[2]  = atf_pkg::REG_MERGE;
    value[0] = {16'd0, thr};
    value[1] = {31'd0, fold};
    value[2] = {31'd0, merge};
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= value[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_threshold = thr;
    cfg_fold      = fold;
    cfg_merge     = merge;
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(8'h61, 8'h7A));
      3, 4:    return 8'($urandom_range(atf_pkg::CHAR_UPPER_A, atf_pkg::CHAR_UPPER_Z));
      5:       return 8'($urandom_range(atf_pkg::CODE_TAB, atf_pkg::CODE_CR));
      6:       return ($urandom_range(0, 1) == 1) ? atf_pkg::CODE_UNIT_SEP
                                                  : atf_pkg::CODE_SPACE;
      7:       return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic read_lists(int n);
    atf_pkg::req_t req;
    logic [8:0]    len;
    logic [7:0]    idx;
    for (int i = 0; i < n; i++) begin
      req = ($urandom_range(0, 1) == 1) ? atf_pkg::REQ_READ_ALPHA
                                        : atf_pkg::REQ_READ_COLLAPSE;
      len = (req == atf_pkg::REQ_READ_ALPHA) ? alpha_len_q : coll_len_q;
      idx = (len != 0 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, len - 1))
                                                    : 8'($urandom);
      send_word(req, 8'($urandom), idx);
    end
  endtask

  task automatic test_reads_before_finish();
    send_word(atf_pkg::REQ_READ_ALPHA, 8'($urandom), 8'h00);
    send_word(atf_pkg::REQ_READ_COLLAPSE, 8'($urandom), 8'hFF);
  endtask

  task automatic test_finish_without_chars();
    send_word(atf_pkg::REQ_COUNT, 8'd0, 8'($urandom));
    send_word(atf_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
  endtask

  // Reset configuration: a zero threshold makes every counted code frequent.
  task automatic test_special_codes();
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_UNIT_SEP, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_SPACE, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'hFF, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CHAR_UPPER_A, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_TAB, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'h80, 8'($urandom));
    send_word(atf_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
    send_word(atf_pkg::REQ_READ_ALPHA, 8'($urandom), 8'h00);
    send_word(atf_pkg::REQ_READ_ALPHA, 8'($urandom), 8'hFF);
    send_word(atf_pkg::REQ_READ_COLLAPSE, 8'($urandom), 8'h00);
  endtask

  // Full threshold with folding and space merging: every code is rare.
  task automatic test_fold_and_merge();
    settle();
    configure(16'hFFFF, 1'b1, 1'b1);
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CHAR_UPPER_A, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'h61, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CHAR_UPPER_Z, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_TAB, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'd10, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_SPACE, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_UNIT_SEP, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, atf_pkg::CODE_CR, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'h62, 8'($urandom));
    send_word(atf_pkg::REQ_COUNT, 8'h62, 8'($urandom));
    send_word(atf_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
    send_word(atf_pkg::REQ_READ_ALPHA, 8'($urandom), 8'h00);
    send_word(atf_pkg::REQ_READ_ALPHA, 8'($urandom), 8'h01);
    send_word(atf_pkg::REQ_READ_COLLAPSE, 8'($urandom), 8'h02);
  endtask

  task automatic test_random_traffic();
    logic [15:0] thr;
    bit          fold;
    bit          merge;
    int          phase_end;
    int          roll;
    int          n_sym;
    int          n_count;
    logic [7:0]  palette [10];
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2:       thr = 16'h0001;
        3:       thr = 16'h8000;
        default: thr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(256, 16384));
      endcase
      fold  = (p == 1) || (p > 1 && $urandom_range(0, 1) == 1);
      merge = (p == 1) || (p > 1 && $urandom_range(0, 1) == 1);
      settle();
      configure(thr, fold, merge);

      // A session over every code makes long lists; at a zero threshold it fills the alphabet.
      if (p == 0 || p == 5) begin
        for (int c = 1; c < SYMBOLS; c++) begin
          send_word(atf_pkg::REQ_COUNT, 8'(c), 8'($urandom));
        end
        repeat ($urandom_range(0, 20)) begin
          send_word(atf_pkg::REQ_COUNT, 8'($urandom), 8'($urandom));
        end
        send_word(atf_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
        read_lists(8);
      end

      phase_end = words_sent + 70;
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 19);
        if (roll < 2) begin
          send_word(atf_pkg::req_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end else begin
          n_sym   = $urandom_range(1, 10);
          n_count = $urandom_range(1, 40);
          for (int i = 0; i < n_sym; i++) begin
            palette[i] = pick_symbol();
          end
          // Skew towards the front of the palette so counts differ widely.
          for (int i = 0; i < n_count; i++) begin
            send_word(atf_pkg::REQ_COUNT,
                      palette[$urandom_range(0, n_sym - 1) % ($urandom_range(0, n_sym - 1) + 1)],
                      8'($urandom));
          end
          // Now and then the session runs on into the next one unfinished.
          if (roll != 2) send_word(atf_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
          read_lists($urandom_range(0, 4));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reads_before_finish();
    test_finish_without_chars();
    test_special_codes();
    test_fold_and_merge();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
